### hdl/pcds_pkg.sv
`default_nettype none

package pcds_pkg;

    localparam int CoordWidth = 32;
    localparam int DevWidth   = 32;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int OpWidth    = CoordWidth + 4;
    localparam int ProdWidth  = 2 * OpWidth;
    localparam int AccWidth   = ProdWidth + 2;
    localparam int RemWidth   = OpWidth + 2;
    localparam int ShortLoop  = 3;
    localparam int InDepth    = 2;
    localparam int OutDepth   = 2;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [DiffWidth-1:0]  diff_t;
    typedef logic signed [AccWidth-1:0]   acc_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   loop_end;
    } point_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   run_last;
        logic   loop_done;
    } result_t;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_SECOND,
        KIND_KEEP,
        KIND_JUDGE
    } kind_t;

    typedef struct packed {
        point_t pt;
        kind_t  kind;
    } work_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_SQRT,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_DIV_DEV,
        ST_MUL_P3,
        ST_MUL_P4,
        ST_DIV_CM,
        ST_MUL_OX,
        ST_DIV_OX,
        ST_MUL_OY,
        ST_DIV_OY,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_DONE
    } back_state_t;

    function automatic logic [OpWidth-1:0] mag_diff(input diff_t v);
        logic [DiffWidth-1:0] u;
        u = v[DiffWidth-1] ? -v : v;
        return OpWidth'(u);
    endfunction

    function automatic logic [ProdWidth-1:0] mag_acc(input acc_t v);
        logic [AccWidth-1:0] u;
        u = v[AccWidth-1] ? -v : v;
        return u[ProdWidth-1:0];
    endfunction

    function automatic coord_t sat_coord(input acc_t v);
        acc_t hi;
        acc_t lo;
        hi = {{(AccWidth-CoordWidth+1){1'b0}}, {(CoordWidth-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            return hi[CoordWidth-1:0];
        end
        else if (v < lo)
        begin
            return lo[CoordWidth-1:0];
        end
        return v[CoordWidth-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/pcds_front.sv
`default_nettype none

module pcds_front #(
    parameter int DEPTH = pcds_pkg::InDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pcds_pkg::point_t point,
    input  logic [31:0]      coarseness,
    output logic             work_valid,
    output pcds_pkg::work_t  work,
    input  logic             deq
);
    import pcds_pkg::*;

    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    work_t            mem [DEPTH];
    logic [IdxW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [1:0]       seen_reg, seen_next;
    kind_t            kind;
    logic             accept;
    logic             take;

    assign full       = (cnt_reg == CntW'(DEPTH));
    assign work_valid = (cnt_reg != '0);
    assign work       = mem[rd_ptr_reg];
    assign accept     = push && !full;
    assign take       = deq && work_valid;

    // Short loops and a zero budget keep every point without any arithmetic.
    always_comb
    begin
        priority if (seen_reg == 2'd0)
        begin
            kind = KIND_FIRST;
        end
        else if (seen_reg == 2'd1)
        begin
            kind = KIND_SECOND;
        end
        else if ((({1'b0, seen_reg} + 3'd1 <= 3'(ShortLoop)) && point.loop_end)
                 || (coarseness == '0))
        begin
            kind = KIND_KEEP;
        end
        else
        begin
            kind = KIND_JUDGE;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        seen_next   = seen_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (point.loop_end)
            begin
                seen_next = 2'd0;
            end
            else if (seen_reg != 2'd3)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CntW'(accept) - CntW'(take);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_ptr_reg] <= '{pt: point, kind: kind};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pcds_arith.sv
`default_nettype none

module pcds_arith (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcds_pkg::arith_ctl_t              ctl,
    input  logic [pcds_pkg::ProdWidth-1:0]    opa,
    input  logic [pcds_pkg::OpWidth-1:0]      opb,
    output pcds_pkg::arith_stat_t             stat,
    output logic [pcds_pkg::ProdWidth-1:0]    res
);
    import pcds_pkg::*;

    localparam int CntW = $clog2(ProdWidth + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    arith_op_t            op_reg, op_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic [ProdWidth-1:0] acc_reg, acc_next;
    logic [ProdWidth-1:0] shf_reg, shf_next;
    logic [RemWidth-1:0]  rem_reg, rem_next;
    logic [OpWidth-1:0]   b_reg, b_next;

    logic [ProdWidth-1:0] mul_sum;
    logic [OpWidth:0]     div_sh;
    logic                 div_ge;
    logic [OpWidth:0]     div_diff;
    logic [RemWidth+1:0]  sq_sh;
    logic [RemWidth+1:0]  sq_trial;
    logic                 sq_ge;
    logic [RemWidth+1:0]  sq_diff;

    assign mul_sum  = acc_reg + (b_reg[0] ? shf_reg : '0);
    assign div_sh   = {rem_reg[OpWidth-1:0], shf_reg[ProdWidth-1]};
    assign div_ge   = (div_sh >= {1'b0, b_reg});
    assign div_diff = div_sh - {1'b0, b_reg};
    // Digit-by-digit square root: the root grows one bit per step in acc.
    assign sq_sh    = {rem_reg, shf_reg[ProdWidth-1 -: 2]};
    assign sq_trial = {2'b00, acc_reg[OpWidth-1:0], 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_diff  = sq_sh - sq_trial;

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = (op_reg == OP_DIV) ? shf_reg : acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        if (!busy_reg && ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            acc_next  = '0;
            shf_next  = opa;
            rem_next  = '0;
            b_next    = opb;
            cnt_next  = (ctl.op == OP_DIV) ? CntW'(ProdWidth) : CntW'(OpWidth);
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    acc_next = mul_sum;
                    shf_next = {shf_reg[ProdWidth-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[OpWidth-1:1]};
                end
                OP_DIV:
                begin
                    rem_next = RemWidth'(div_ge ? div_diff : div_sh);
                    shf_next = {shf_reg[ProdWidth-2:0], div_ge};
                end
                OP_SQRT:
                begin
                    rem_next = sq_ge ? sq_diff[RemWidth-1:0] : sq_sh[RemWidth-1:0];
                    acc_next = {acc_reg[ProdWidth-2:0], sq_ge};
                    shf_next = {shf_reg[ProdWidth-3:0], 2'b00};
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        shf_reg <= shf_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pcds_back.sv
`default_nettype none

module pcds_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           work_valid,
    input  pcds_pkg::work_t                work,
    output logic                           deq,
    input  logic [31:0]                    coarseness,
    input  logic                           res_full,
    output logic                           res_push,
    output pcds_pkg::result_t              res_item,
    output pcds_pkg::arith_ctl_t           actl,
    output logic [pcds_pkg::ProdWidth-1:0] aopa,
    output logic [pcds_pkg::OpWidth-1:0]   aopb,
    input  pcds_pkg::arith_stat_t          astat,
    input  logic [pcds_pkg::ProdWidth-1:0] ares
);
    import pcds_pkg::*;

    back_state_t           state_reg, state_next;
    logic                  issued_reg, issued_next;
    coord_t                older_x_reg, older_x_next, older_y_reg, older_y_next;
    coord_t                pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic [DevWidth-1:0]   total_reg, total_next;
    point_t                cur_reg, cur_next;
    diff_t                 dx_reg, dx_next, dy_reg, dy_next;
    diff_t                 ex_reg, ex_next, ey_reg, ey_next;
    acc_t                  acc_reg, acc_next;
    logic [OpWidth-1:0]    len_reg, len_next;
    logic [OpWidth-1:0]    cm_reg, cm_next;
    logic                  cm_neg_reg, cm_neg_next;
    coord_t                lx_reg, lx_next;

    acc_t                  prod;
    acc_t                  quot;
    acc_t                  l2;
    logic [DevWidth-1:0]   dev;
    logic [DevWidth:0]     tsum;
    logic [DevWidth-1:0]   tnew;
    logic                  off_neg;
    acc_t                  off;
    logic                  is_math;
    logic                  got;

    assign prod    = $signed({2'b00, ares});
    assign quot    = prod;
    assign l2      = acc_reg + prod;
    assign dev     = (|ares[ProdWidth-1:DevWidth]) ? '1 : ares[DevWidth-1:0];
    assign tsum    = {1'b0, total_reg} + {1'b0, dev};
    assign tnew    = tsum[DevWidth] ? '1 : tsum[DevWidth-1:0];
    assign off_neg = ((state_reg == ST_DIV_OX) ? dx_reg[DiffWidth-1] : dy_reg[DiffWidth-1])
                     ^ cm_neg_reg;
    assign off     = off_neg ? -quot : quot;
    assign is_math = (state_reg != ST_IDLE) && (state_reg != ST_EMIT_A)
                     && (state_reg != ST_EMIT_B) && (state_reg != ST_DONE);
    assign got     = is_math && issued_reg && astat.done;

    // Operand selection for the shared arithmetic unit.
    always_comb
    begin
        actl.start = is_math && !issued_reg;
        actl.op    = OP_MUL;
        aopa       = '0;
        aopb       = '0;
        unique case (state_reg)
            ST_MUL_DX:
            begin
                aopa = ProdWidth'(mag_diff(dx_reg));
                aopb = mag_diff(dx_reg);
            end
            ST_MUL_DY:
            begin
                aopa = ProdWidth'(mag_diff(dy_reg));
                aopb = mag_diff(dy_reg);
            end
            ST_SQRT:
            begin
                actl.op = OP_SQRT;
                aopa    = acc_reg[ProdWidth-1:0];
            end
            ST_MUL_P1:
            begin
                aopa = ProdWidth'(mag_diff(ex_reg));
                aopb = mag_diff(dy_reg);
            end
            ST_MUL_P2:
            begin
                aopa = ProdWidth'(mag_diff(ey_reg));
                aopb = mag_diff(dx_reg);
            end
            ST_MUL_P3:
            begin
                aopa = ProdWidth'(mag_diff(ex_reg));
                aopb = mag_diff(dx_reg);
            end
            ST_MUL_P4:
            begin
                aopa = ProdWidth'(mag_diff(ey_reg));
                aopb = mag_diff(dy_reg);
            end
            ST_DIV_DEV, ST_DIV_CM:
            begin
                actl.op = OP_DIV;
                aopa    = mag_acc(acc_reg);
                aopb    = len_reg;
            end
            ST_MUL_OX:
            begin
                aopa = ProdWidth'(mag_diff(dx_reg));
                aopb = cm_reg;
            end
            ST_MUL_OY:
            begin
                aopa = ProdWidth'(mag_diff(dy_reg));
                aopb = cm_reg;
            end
            ST_DIV_OX, ST_DIV_OY:
            begin
                actl.op = OP_DIV;
                aopa    = acc_reg[ProdWidth-1:0];
                aopb    = len_reg;
            end
            default:
            begin
                actl.op = OP_MUL;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        older_x_next = older_x_reg;
        older_y_next = older_y_reg;
        pend_x_next  = pend_x_reg;
        pend_y_next  = pend_y_reg;
        total_next   = total_reg;
        cur_next     = cur_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        cm_next      = cm_reg;
        cm_neg_next  = cm_neg_reg;
        lx_next      = lx_reg;
        deq          = 1'b0;
        res_push     = 1'b0;
        res_item     = '{out_x: pend_x_reg, out_y: pend_y_reg, run_last: 1'b1,
                         loop_done: cur_reg.loop_end};

        if (is_math)
        begin
            if (!issued_reg)
            begin
                issued_next = 1'b1;
            end
            else if (astat.done)
            begin
                issued_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    deq      = 1'b1;
                    cur_next = work.pt;
                    dx_next  = DiffWidth'(pend_x_reg) - DiffWidth'(older_x_reg);
                    dy_next  = DiffWidth'(pend_y_reg) - DiffWidth'(older_y_reg);
                    ex_next  = DiffWidth'(work.pt.point_x) - DiffWidth'(pend_x_reg);
                    ey_next  = DiffWidth'(work.pt.point_y) - DiffWidth'(pend_y_reg);
                    unique case (work.kind)
                        KIND_FIRST:
                        begin
                            pend_x_next = work.pt.point_x;
                            pend_y_next = work.pt.point_y;
                            state_next  = ST_EMIT_B;
                        end
                        KIND_SECOND:
                        begin
                            older_x_next = pend_x_reg;
                            older_y_next = pend_y_reg;
                            pend_x_next  = work.pt.point_x;
                            pend_y_next  = work.pt.point_y;
                            state_next   = work.pt.loop_end ? ST_EMIT_B : ST_DONE;
                        end
                        KIND_KEEP:
                        begin
                            state_next = ST_EMIT_A;
                        end
                        KIND_JUDGE:
                        begin
                            state_next = ST_MUL_DX;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL_DX:
            begin
                if (got)
                begin
                    acc_next   = prod;
                    state_next = ST_MUL_DY;
                end
            end
            ST_MUL_DY:
            begin
                if (got)
                begin
                    acc_next = l2;
                    // A zero-length reference keeps the point and leaves the total alone.
                    state_next = (l2 == '0) ? ST_EMIT_A : ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (got)
                begin
                    len_next   = ares[OpWidth-1:0];
                    state_next = ST_MUL_P1;
                end
            end
            ST_MUL_P1, ST_MUL_P3:
            begin
                if (got)
                begin
                    acc_next = (ex_reg[DiffWidth-1] ^ ((state_reg == ST_MUL_P1) ?
                               dy_reg[DiffWidth-1] : dx_reg[DiffWidth-1])) ? -prod : prod;
                    state_next = (state_reg == ST_MUL_P1) ? ST_MUL_P2 : ST_MUL_P4;
                end
            end
            ST_MUL_P2:
            begin
                if (got)
                begin
                    acc_next   = (ey_reg[DiffWidth-1] ^ dx_reg[DiffWidth-1]) ?
                                 acc_reg + prod : acc_reg - prod;
                    state_next = ST_DIV_DEV;
                end
            end
            ST_MUL_P4:
            begin
                if (got)
                begin
                    acc_next   = (ey_reg[DiffWidth-1] ^ dy_reg[DiffWidth-1]) ?
                                 acc_reg - prod : acc_reg + prod;
                    state_next = ST_DIV_CM;
                end
            end
            ST_DIV_DEV:
            begin
                if (got)
                begin
                    if (tnew > coarseness)
                    begin
                        total_next = '0;
                        state_next = ST_EMIT_A;
                    end
                    else
                    begin
                        total_next = tnew;
                        state_next = ST_MUL_P3;
                    end
                end
            end
            ST_DIV_CM:
            begin
                if (got)
                begin
                    cm_next     = ares[OpWidth-1:0];
                    cm_neg_next = acc_reg[AccWidth-1];
                    state_next  = ST_MUL_OX;
                end
            end
            ST_MUL_OX, ST_MUL_OY:
            begin
                if (got)
                begin
                    acc_next   = prod;
                    state_next = (state_reg == ST_MUL_OX) ? ST_DIV_OX : ST_DIV_OY;
                end
            end
            ST_DIV_OX:
            begin
                if (got)
                begin
                    lx_next    = sat_coord(AccWidth'(pend_x_reg) + off);
                    state_next = ST_MUL_OY;
                end
            end
            ST_DIV_OY:
            begin
                if (got)
                begin
                    pend_x_next = lx_reg;
                    pend_y_next = sat_coord(AccWidth'(pend_y_reg) + off);
                    state_next  = cur_reg.loop_end ? ST_EMIT_B : ST_DONE;
                end
            end
            ST_EMIT_A:
            begin
                res_item.run_last  = !cur_reg.loop_end;
                res_item.loop_done = 1'b0;
                if (!res_full)
                begin
                    res_push     = 1'b1;
                    older_x_next = pend_x_reg;
                    older_y_next = pend_y_reg;
                    pend_x_next  = cur_reg.point_x;
                    pend_y_next  = cur_reg.point_y;
                    state_next   = cur_reg.loop_end ? ST_EMIT_B : ST_DONE;
                end
            end
            ST_EMIT_B:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (cur_reg.loop_end)
                begin
                    total_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        acc_reg    <= acc_next;
        len_reg    <= len_next;
        cm_reg     <= cm_next;
        cm_neg_reg <= cm_neg_next;
        lx_reg     <= lx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            older_x_reg <= '0;
            older_y_reg <= '0;
            pend_x_reg  <= '0;
            pend_y_reg  <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            older_x_reg <= older_x_next;
            older_y_reg <= older_y_next;
            pend_x_reg  <= pend_x_next;
            pend_y_reg  <= pend_y_next;
            total_reg   <= total_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pcds_outq.sv
`default_nettype none

module pcds_outq #(
    parameter int DEPTH = pcds_pkg::OutDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pcds_pkg::result_t item,
    input  logic              pop,
    output logic              empty,
    output pcds_pkg::result_t result
);
    import pcds_pkg::*;

    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [IdxW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             wr;
    logic             rd;

    assign full   = (cnt_reg == CntW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign result = mem[rd_ptr_reg];
    assign wr     = push && !full;
    assign rd     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CntW'(wr) - CntW'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/polyline_cumulative_deviation_simplifier_core.sv
// Loop simplifier: push the points of a closed loop (signed Q16.16, loop_end on the last
// point) and pop the simplified points. A point whose total perpendicular deviation from
// the line through the last kept point and the pending point stays within coarseness
// slides the pending point onto that line; otherwise it is kept. Points are handled one
// at a time. The first two points of a loop, points kept by a zero coarseness and the
// third point of a short loop skip the arithmetic unit. A judged point runs through one
// shared bit-serial unit: at most eight multiplies and one square root of CoordWidth+4
// steps and four divides of 2*CoordWidth+8 steps; a full result queue holds the back end
// before it emits. The input queue takes new requests while a point is being worked on,
// until it is full, and the result queue holds up to OUT_DEPTH results.
`default_nettype none

module polyline_cumulative_deviation_simplifier_core #(
    parameter int IN_DEPTH  = pcds_pkg::InDepth,
    parameter int OUT_DEPTH = pcds_pkg::OutDepth
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pcds_pkg::point_t  point,
    input  logic              pop,
    output logic              empty,
    output pcds_pkg::result_t result,
    input  logic              coarseness_we,
    input  logic [31:0]       coarseness
);
    import pcds_pkg::*;

    logic [31:0]          coarseness_reg;
    logic                 work_valid;
    work_t                work;
    logic                 deq;
    logic                 res_full;
    logic                 res_push;
    result_t              res_item;
    arith_ctl_t           actl;
    arith_stat_t          astat;
    logic [ProdWidth-1:0] aopa;
    logic [OpWidth-1:0]   aopb;
    logic [ProdWidth-1:0] ares;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coarseness_reg <= '0;
        end
        else if (coarseness_we)
        begin
            coarseness_reg <= coarseness;
        end
    end

    pcds_front #(.DEPTH(IN_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .point      (point),
        .coarseness (coarseness_reg),
        .work_valid (work_valid),
        .work       (work),
        .deq        (deq)
    );

    pcds_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (actl),
        .opa   (aopa),
        .opb   (aopb),
        .stat  (astat),
        .res   (ares)
    );

    pcds_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work       (work),
        .deq        (deq),
        .coarseness (coarseness_reg),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_item   (res_item),
        .actl       (actl),
        .aopa       (aopa),
        .aopb       (aopb),
        .astat      (astat),
        .ares       (ares)
    );

    pcds_outq #(.DEPTH(OUT_DEPTH)) u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .full   (res_full),
        .item   (res_item),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

`default_nettype wire

### hdl/pcds_checker.sv
`default_nettype none

module pcds_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  pcds_pkg::point_t  point,
    input  logic              pop,
    input  logic              empty,
    input  pcds_pkg::result_t result
);

    // The end of a loop is always the last result of its request.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.loop_done |-> result.run_last)
        else $error("loop_done without run_last");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> empty && !full)
        else $error("queues not empty in reset");

    // The input queue only fills up by taking a request.
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        !full && !push |=> !full)
        else $error("full rose without a request");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");

endmodule

bind polyline_cumulative_deviation_simplifier_core pcds_checker u_pcds_checker (.*);

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;
    import pcds_pkg::*;

    localparam longint CycleLimit = 20_000_000;
    localparam int     DrainWait  = 2500;
    localparam logic [31:0] DevMax = 32'hFFFF_FFFF;

    class loop_scoreboard;
        logic [31:0] coarse;
        longint old_x, old_y, pend_x, pend_y;
        logic [31:0] total;
        int seen;
        result_t want[$];
        int errors;
        int reported;

        function new();
            coarse = 0;
            old_x = 0; old_y = 0; pend_x = 0; pend_y = 0;
            total = 0;
            seen = 0;
            errors = 0;
            reported = 0;
        endfunction

        function logic [127:0] cap62(logic [127:0] q);
            logic [127:0] lim;
            lim = 128'd1 << 62;
            return (q > lim) ? lim : q;
        endfunction

        function longint clamp_coord(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function logic [63:0] isqrt(logic [127:0] n);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 63; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (({64'd0, t} * {64'd0, t}) <= n)
                begin
                    r = t;
                end
            end
            return r;
        endfunction

        // Offset along one axis of the reference segment, rounded toward zero.
        function longint axis_offset(longint axis, longint comp, logic [127:0] len);
            logic signed [127:0] p;
            logic [127:0] mag;
            p = 128'(axis) * 128'(comp);
            mag = cap62(((p < 0) ? -p : p) / len);
            return (p < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        // Returns 1 when the point is kept; otherwise gives the landing point.
        function bit judge_point(longint px, longint py, output longint lx, output longint ly);
            longint dx, dy, ex, ey, comp;
            logic signed [127:0] cr, dt;
            logic [127:0] l2, len, q, cm;
            logic [32:0] sum;
            logic [31:0] dev;
            lx = 0;
            ly = 0;
            dx = pend_x - old_x;
            dy = pend_y - old_y;
            ex = px - pend_x;
            ey = py - pend_y;
            l2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
            if (l2 == 0)
            begin
                return 1;
            end
            len = {64'd0, isqrt(l2)};
            cr = 128'(ex) * 128'(dy) - 128'(ey) * 128'(dx);
            q = ((cr < 0) ? -cr : cr) / len;
            dev = (q > {96'd0, DevMax}) ? DevMax : q[31:0];
            sum = {1'b0, total} + {1'b0, dev};
            total = sum[32] ? DevMax : sum[31:0];
            if (total > coarse)
            begin
                total = 0;
                return 1;
            end
            dt = 128'(ex) * 128'(dx) + 128'(ey) * 128'(dy);
            cm = cap62(((dt < 0) ? -dt : dt) / len);
            comp = (dt < 0) ? -longint'(cm) : longint'(cm);
            lx = clamp_coord(pend_x + axis_offset(dx, comp, len));
            ly = clamp_coord(pend_y + axis_offset(dy, comp, len));
            return 0;
        endfunction

        function void note_point(point_t p);
            longint x, y, lx, ly;
            bit keep;
            result_t outs[$];
            result_t r;
            x = longint'(p.point_x);
            y = longint'(p.point_y);
            if (seen == 0)
            begin
                outs.insert(outs.size(), '{coord_t'(x), coord_t'(y), 1'b0, 1'b0});
                pend_x = x;
                pend_y = y;
                seen = 1;
            end
            else if (seen == 1)
            begin
                old_x = pend_x;
                old_y = pend_y;
                pend_x = x;
                pend_y = y;
                seen = 2;
                if (p.loop_end)
                begin
                    outs.insert(outs.size(), '{coord_t'(pend_x), coord_t'(pend_y), 1'b0, 1'b0});
                end
            end
            else
            begin
                // The third point of a short loop and a zero budget skip the judgement.
                if ((seen + 1 <= ShortLoop && p.loop_end) || coarse == 0)
                begin
                    keep = 1;
                end
                else
                begin
                    keep = judge_point(x, y, lx, ly);
                end
                if (keep)
                begin
                    outs.insert(outs.size(), '{coord_t'(pend_x), coord_t'(pend_y), 1'b0, 1'b0});
                    old_x = pend_x;
                    old_y = pend_y;
                    pend_x = x;
                    pend_y = y;
                end
                else
                begin
                    pend_x = lx;
                    pend_y = ly;
                end
                if (p.loop_end)
                begin
                    outs.insert(outs.size(), '{coord_t'(pend_x), coord_t'(pend_y), 1'b0, 1'b0});
                end
                seen = 3;
            end
            if (outs.size() > 0)
            begin
                outs[outs.size()-1].run_last = 1'b1;
                outs[outs.size()-1].loop_done = p.loop_end;
            end
            if (p.loop_end)
            begin
                seen = 0;
                total = 0;
            end
            foreach (outs[i])
            begin
                r = outs[i];
                want.insert(want.size(), r);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (want.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result x=%h y=%h last=%b done=%b",
                             got.out_x, got.out_y, got.run_last, got.loop_done);
                end
                return;
            end
            exp_r = want.pop_front();
            if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y
                || got.run_last !== exp_r.run_last || got.loop_done !== exp_r.loop_done)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch: expected x=%h y=%h last=%b done=%b,",
                             exp_r.out_x, exp_r.out_y, exp_r.run_last, exp_r.loop_done);
                    $display("          got x=%h y=%h last=%b done=%b",
                             got.out_x, got.out_y, got.run_last, got.loop_done);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    point_t      point;
    logic        pop;
    logic        empty;
    result_t     result;
    logic        coarseness_we;
    logic [31:0] coarseness;

    loop_scoreboard sb;
    longint cycles;
    bit hold_rx;

    polyline_cumulative_deviation_simplifier_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .point(point),
        .pop(pop),
        .empty(empty),
        .result(result),
        .coarseness_we(coarseness_we),
        .coarseness(coarseness)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        if (rst_n && pop && !empty)
        begin
            sb.check_result(result);
        end
    end

    // Receiver: mostly short stalls, a few long ones, and one long hold-off on request.
    initial
    begin
        int r;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                pop = 1'b0;
                repeat (3000) @(negedge clk);
                hold_rx = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                pop = 1'b1;
            end
            else if (r < 75)
            begin
                pop = 1'b1;
                repeat ($urandom_range(20, 200)) @(negedge clk);
            end
            else if (r < 96)
            begin
                pop = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                pop = 1'b0;
                repeat ($urandom_range(20, 400)) @(negedge clk);
            end
        end
    end

    task automatic send_point(input coord_t x, input coord_t y, input logic last);
        @(negedge clk);
        push = 1'b1;
        point = '{x, y, last};
        do
            @(posedge clk);
        while (full);
        sb.note_point(point);
    endtask

    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 55)
        begin
            @(negedge clk);
            push = 1'b0;
            if (r < 95)
            begin
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                repeat ($urandom_range(30, 600)) @(negedge clk);
            end
        end
    endtask

    // Budget changes only once all results are out and the core has finished its point.
    task automatic set_coarseness(input logic [31:0] v);
        @(negedge clk);
        push = 1'b0;
        while (sb.want.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainWait) @(negedge clk);
        coarseness_we = 1'b1;
        coarseness = v;
        @(negedge clk);
        coarseness_we = 1'b0;
        sb.coarse = v;
    endtask

    task automatic random_loop(output int count);
        int n;
        int scale;
        longint bx, by, vx, vy, nz, px, py;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        scale = $urandom_range(4, 24);
        bx = longint'($signed($urandom)) >>> $urandom_range(0, 8);
        by = longint'($signed($urandom)) >>> $urandom_range(0, 8);
        vx = longint'($signed($urandom)) >>> (32 - scale);
        vy = longint'($signed($urandom)) >>> (32 - scale);
        nz = longint'(1) << $urandom_range(0, scale);
        for (int i = 0; i < n; i++)
        begin
            px = bx + vx * i + longint'($urandom_range(0, 2 * nz)) - nz;
            py = by + vy * i + longint'($urandom_range(0, 2 * nz)) - nz;
            if ($urandom_range(0, 9) == 0)
            begin
                px = longint'($signed($urandom));
                py = longint'($signed($urandom));
            end
            send_point(coord_t'(px), coord_t'(py), i == n - 1);
            sender_gap();
        end
        count = n;
    endtask

    initial
    begin
        logic [31:0] budgets[6];
        int sent;
        int n_pts;
        sb = new();
        cycles = 0;
        hold_rx = 0;
        push = 1'b0;
        point = '0;
        coarseness_we = 1'b0;
        coarseness = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero budget: every loop passes unchanged, extremes included.
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_point(32'sh0000_0001, -32'sh0000_0001, 1'b1);
        send_point(32'sh0000_0005, 32'sh0000_0005, 1'b1);
        send_point(32'sh0000_0001, 32'sh0000_0002, 1'b0);
        send_point(32'sh0000_0003, 32'sh0000_0004, 1'b1);

        set_coarseness(32'hFFFF_FFFF);
        // A repeated point gives a zero-length reference segment.
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(10, 10, 1'b0);
        send_point(20, 3, 1'b0);
        send_point(30, 0, 1'b1);
        // Three-point loop.
        send_point(0, 0, 1'b0);
        send_point(100, 0, 1'b0);
        send_point(200, 5, 1'b1);
        // A unit reference segment throws the projection out to the edges of the coordinate range.
        send_point(0, 0, 1'b0);
        send_point(1, 0, 1'b0);
        send_point(32'sh7FFF_FFFF, 0, 1'b0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 1'b1);

        set_coarseness(32'd1);
        send_point(0, 0, 1'b0);
        send_point(32'sh0001_0000, 0, 1'b0);
        send_point(32'sh0002_0000, 32'sh0001_0000, 1'b0);
        send_point(32'sh0003_0000, 0, 1'b0);
        send_point(0, 0, 1'b1);

        budgets[0] = 32'd0;
        budgets[1] = 32'd1;
        budgets[2] = $urandom_range(32'h0000_4000, 32'h0010_0000);
        budgets[3] = $urandom;
        budgets[4] = 32'hFFFF_FFFF;
        budgets[5] = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
        foreach (budgets[k])
        begin
            set_coarseness(budgets[k]);
            if (k == 2)
            begin
                hold_rx = 1;
            end
            sent = 0;
            while (sent < 255)
            begin
                random_loop(n_pts);
                sent += n_pts;
            end
        end

        @(negedge clk);
        push = 1'b0;
        while (sb.want.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainWait) @(negedge clk);
        if (sb.errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### polyline_cumulative_deviation_simplifier_core.f
hdl/pcds_pkg.sv
hdl/pcds_front.sv
hdl/pcds_arith.sv
hdl/pcds_back.sv
hdl/pcds_outq.sv
hdl/polyline_cumulative_deviation_simplifier_core.sv
hdl/pcds_checker.sv
bench/tb.sv
